// File: rtl/mspc_pkg.sv
package mspc_pkg;

  // Widest channel index the token carries (CHANNELS up to 64)
  localparam int IDX_W = 6;

  localparam int CAL_ENTRIES = 26;
  localparam int CAL_W       = 5;

  // Calibration knots, unsigned Q8.8
  localparam logic [15:0] CAL_Q88 [CAL_ENTRIES] = '{
    16'd0,     16'd840,   16'd1756,  16'd2787,  16'd3913,  16'd5211,  16'd6681,
    16'd8379,  16'd10441, 16'd12846, 16'd16015, 16'd20367, 16'd26742, 16'd34835,
    16'd41745, 16'd46574, 16'd50105, 16'd53026, 16'd55354, 16'd57263, 16'd58981,
    16'd60451, 16'd61749, 16'd62894, 16'd63944, 16'd64898
  };

  localparam logic [2:0] ST_TICK      = 3'd0;
  localparam logic [2:0] ST_UNCHANGED = 3'd1;
  localparam logic [2:0] ST_UPDATED   = 3'd2;
  localparam logic [2:0] ST_ALLOCATED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Search token passed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [7:0]       hit_last;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } mspc_token_t;

  // Write command broadcast to the row
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       pin;
    logic [7:0]       duty;
    logic [7:0]       req;
  } mspc_wr_t;

endpackage

// File: rtl/multichannel_soft_pwm_calibrated.sv
// Channel | Beat fields                                          | Role
// s_axis  | tuser: op; tdata: pin_number[7:0], level_request[23:8] | items in
// m_axis  | tdata: channel_levels[15:0], channel_used[19:16],     | results out
//         |        set_status[22:20], mapped_duty[30:23]          |
// A tick's beat passes through the S_DONE state into the result register once that
// is free; the next beat can be taken once the state is back in S_IDLE. A set item
// walks a token down the row of CHANNELS cells; for a new or changed level, the
// calibration map then scans its knot table one entry a cycle and runs a 4-step
// divide. One item is in flight at a time; the result
// register lets the next item in while a result waits. Synchronous reset
// clears every channel; no clearing pass is needed.
module multichannel_soft_pwm_calibrated
  import mspc_pkg::*;
#(
  parameter int CHANNELS     = 16,
  parameter int PERIOD_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,  // op
  input  logic [23:0] s_tdata,  // pin_number, level_request
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // channel_levels, channel_used, set_status, mapped_duty, pad
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_MAP    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]       state;
  logic [7:0]       q_pin;
  logic [7:0]       q_req;
  logic             accept;
  logic             tick;
  logic             launch;
  logic             map_start;
  logic             map_done;
  logic [7:0]       map_duty;
  logic [IDX_W-1:0] tgt_idx;
  logic [3:0]       res_used;
  logic [2:0]       res_status;
  logic [7:0]       res_duty;
  logic [15:0]      levels16;
  logic [CHANNELS-1:0] lvl;
  mspc_token_t      tok [CHANNELS+1];
  mspc_wr_t         wr;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign tick     = accept && !s_tuser;

  // token enters the first cell the cycle after a set beat is taken
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch;
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
    mspc_cell #(.IDX(c), .PERIOD_SLOTS(PERIOD_SLOTS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tick     (tick),
      .query_pin(q_pin),
      .wr       (wr),
      .tok_in   (tok[c]),
      .tok_out  (tok[c+1]),
      .level    (lvl[c])
    );
  end

  mspc_map #(.PERIOD_SLOTS(PERIOD_SLOTS)) u_map (
    .clk  (clk),
    .rst  (rst),
    .start(map_start),
    .v    (q_req),
    .done (map_done),
    .duty (map_duty)
  );

  // only the first sixteen channels are reported
  always_comb begin
    levels16 = '0;
    for (int c = 0; c < CHANNELS && c < 16; c++) begin
      levels16[c] = lvl[c];
    end
  end

  always_comb begin
    wr.en   = (state == S_MAP) && map_done;
    wr.idx  = tgt_idx;
    wr.pin  = q_pin;
    wr.duty = map_duty;
    wr.req  = q_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      map_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      launch    <= 1'b0;
      map_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            q_pin      <= s_tdata[7:0];
            q_req      <= (s_tdata[23:16] != 8'd0) ? 8'd255 : s_tdata[15:8];
            res_used   <= '0;
            res_status <= ST_TICK;
            res_duty   <= '0;
            if (s_tuser) begin
              launch <= 1'b1;
              state  <= S_SEARCH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          if (tok[CHANNELS].valid) begin
            if (tok[CHANNELS].hit) begin
              res_used <= tok[CHANNELS].hit_idx[3:0];
              tgt_idx  <= tok[CHANNELS].hit_idx;
              if (tok[CHANNELS].hit_last == q_req) begin
                res_status <= ST_UNCHANGED;
                state      <= S_DONE;
              end else begin
                res_status <= ST_UPDATED;
                map_start  <= 1'b1;
                state      <= S_MAP;
              end
            end else if (tok[CHANNELS].free) begin
              res_used   <= tok[CHANNELS].free_idx[3:0];
              tgt_idx    <= tok[CHANNELS].free_idx;
              res_status <= ST_ALLOCATED;
              map_start  <= 1'b1;
              state      <= S_MAP;
            end else begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end
          end
        end
        S_MAP: begin
          if (map_done) begin
            res_duty <= map_duty;
            state    <= S_DONE;
          end
        end
        default: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {1'b0, res_duty, res_status, res_used, levels16};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/mspc_cell.sv
module mspc_cell
  import mspc_pkg::*;
#(
  parameter int IDX          = 0,
  parameter int PERIOD_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [7:0]  query_pin,
  input  mspc_wr_t    wr,
  input  mspc_token_t tok_in,
  output mspc_token_t tok_out,
  output logic        level
);

  localparam int SW = $clog2(PERIOD_SLOTS);
  localparam int CW = (SW > 8) ? SW : 8;
  localparam logic [SW-1:0] SLOT_LAST = SW'(PERIOD_SLOTS - 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic          in_use;
  logic [7:0]    pin;
  logic [7:0]    duty;
  logic [7:0]    last_req;
  logic [SW-1:0] slot;
  logic          wr_me;
  logic          slot_eq;
  mspc_token_t   tok_next;

  assign wr_me   = wr.en && (wr.idx == MY_IDX);
  assign slot_eq = (CW'(slot) == CW'(duty));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= 1'b0;
      pin      <= '0;
      duty     <= '0;
      last_req <= '0;
      slot     <= '0;
      level    <= 1'b0;
    end else if (wr_me) begin
      in_use   <= 1'b1;
      pin      <= wr.pin;
      duty     <= wr.duty;
      last_req <= wr.req;
      slot     <= '0;
    end else if (tick) begin
      if (in_use && pin != 8'd0) begin
        if (duty == 8'd0) begin
          level <= 1'b0;
        end else if (slot == '0) begin
          level <= 1'b1;
        end else if (slot_eq) begin
          level <= 1'b0;
        end
      end
      slot <= (slot == SLOT_LAST) ? '0 : slot + SW'(1);
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid) begin
      if (!tok_in.hit && in_use && pin == query_pin) begin
        tok_next.hit      = 1'b1;
        tok_next.hit_idx  = MY_IDX;
        tok_next.hit_last = last_req;
      end
      if (!tok_in.free && !in_use) begin
        tok_next.free     = 1'b1;
        tok_next.free_idx = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// File: rtl/mspc_map.sv
module mspc_map
  import mspc_pkg::*;
#(
  parameter int PERIOD_SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] v,
  output logic       done,
  output logic [7:0] duty
);

  localparam int TOP = (PERIOD_SLOTS - 1 < 255) ? PERIOD_SLOTS - 1 : 255;
  localparam logic [8:0] TOP9 = 9'(TOP);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SCAN = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_SUM  = 2'd3;

  logic [1:0]       state;
  logic [7:0]       val;
  logic [CAL_W-1:0] k;
  logic [CAL_W-1:0] seg;
  logic [19:0]      rem;
  logic [15:0]      den;
  logic [3:0]       quo;
  logic [1:0]       bitn;
  logic [15:0]      vq;
  logic [15:0]      base;
  logic [19:0]      den_sh;
  logic [8:0]       sum;

  assign vq     = {val, 8'd0};
  assign base   = CAL_Q88[k - CAL_W'(1)];
  assign den_sh = 20'(den) << bitn;
  assign sum    = 9'(seg) * 9'd10 + 9'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            val <= v;
            k   <= '0;
            if (v == 8'd0 || v == 8'd255) begin
              duty <= (9'(v) > TOP9) ? TOP9[7:0] : v;
              done <= 1'b1;
            end else begin
              state <= M_SCAN;
            end
          end
        end
        M_SCAN: begin
          if (vq < CAL_Q88[k]) begin
            if (k == '0) begin
              duty  <= TOP9[7:0];
              done  <= 1'b1;
              state <= M_IDLE;
            end else begin
              seg   <= k - CAL_W'(1);
              // numerator is (v*256 - knot) * 10, quotient stays below 10
              rem   <= (20'(vq - base) << 3) + (20'(vq - base) << 1);
              den   <= CAL_Q88[k] - base;
              quo   <= '0;
              bitn  <= 2'd3;
              state <= M_DIV;
            end
          end else if (k == CAL_W'(CAL_ENTRIES - 1)) begin
            duty  <= TOP9[7:0];
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            k <= k + CAL_W'(1);
          end
        end
        M_DIV: begin
          if (den != 16'd0 && rem >= den_sh) begin
            rem       <= rem - den_sh;
            quo[bitn] <= 1'b1;
          end
          if (bitn == 2'd0) begin
            state <= M_SUM;
          end else begin
            bitn <= bitn - 2'd1;
          end
        end
        M_SUM: begin
          duty  <= (sum > TOP9) ? TOP9[7:0] : sum[7:0];
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mspc_checker.sv
module mspc_checker
  import mspc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[22:20] == ST_TICK || m_tdata[22:20] == ST_UNCHANGED ||
      m_tdata[22:20] == ST_UPDATED || m_tdata[22:20] == ST_ALLOCATED ||
      m_tdata[22:20] == ST_FULL)
    else $error("bad status");

  a_tick: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22:20] == ST_TICK |-> m_tdata[30:16] == 15'd0)
    else $error("tick result carries set fields");

  a_nostore: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[22:20] == ST_UNCHANGED || m_tdata[22:20] == ST_FULL)
      |-> m_tdata[30:23] == 8'd0)
    else $error("duty reported without store");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid out of reset");

endmodule

bind multichannel_soft_pwm_calibrated mspc_checker u_mspc_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mspc_pkg::*;

  localparam int NCH = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  pin;
    logic [15:0] req;
  } pwm_item_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic [2:0]  status;
    logic [3:0]  chan;
    logic [15:0] levels;
  } pwm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tuser = 1'b0;
  logic [23:0] s_tdata = '0;
  logic s_tready;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;

  multichannel_soft_pwm_calibrated DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the channel table
  logic       sh_used  [NCH];
  logic [7:0] sh_pin   [NCH];
  logic [7:0] sh_duty  [NCH];
  logic [7:0] sh_last  [NCH];
  logic [7:0] sh_slot  [NCH];
  logic       sh_level [NCH];

  pwm_item_t   pending_items[$];
  pwm_result_t expected_results[$];

  int errors = 0;
  int cycles = 0;
  int n_ticks = 0, n_sets = 0, n_full = 0, n_results = 0;
  bit quiet = 1'b0;      // no random idling in this stretch
  bit hold_rx = 1'b0;    // receiver held off
  bit stim_done = 1'b0;

  function automatic logic [7:0] calibrate(logic [7:0] v);
    int k;
    int lo;
    int hi;
    int d;
    if (v == 8'd0 || v == 8'd255) return v;
    for (k = 0; k < CAL_ENTRIES; k++)
      if (int'(v) * 256 < int'(CAL_Q88[k])) break;
    if (k >= CAL_ENTRIES || k == 0) return 8'd255;
    lo = int'(CAL_Q88[k-1]);
    hi = int'(CAL_Q88[k]);
    d = (k - 1) * 10 + ((hi != lo) ? ((int'(v) * 256 - lo) * 10) / (hi - lo) : 0);
    if (d > 255) d = 255;
    return d[7:0];
  endfunction

  function automatic pwm_result_t advance_pwm(pwm_item_t it);
    pwm_result_t r;
    int found;
    logic [7:0] v;
    r = '0;
    found = -1;
    if (it.op == OP_TICK) begin
      for (int c = 0; c < NCH; c++) begin
        if (sh_used[c] && sh_pin[c] != 8'd0) begin
          if (sh_duty[c] == 8'd0) sh_level[c] = 1'b0;
          else if (sh_slot[c] == 8'd0) sh_level[c] = 1'b1;
          else if (sh_slot[c] == sh_duty[c]) sh_level[c] = 1'b0;
        end
        sh_slot[c] = sh_slot[c] + 8'd1;
      end
      r.status = ST_TICK;
    end else begin
      v = (it.req > 16'd255) ? 8'd255 : it.req[7:0];
      for (int c = 0; c < NCH; c++)
        if (found < 0 && sh_used[c] && sh_pin[c] == it.pin) found = c;
      if (found >= 0) begin
        r.chan = found[3:0];
        if (sh_last[found] == v) r.status = ST_UNCHANGED;
        else begin
          r.status = ST_UPDATED;
          r.duty = calibrate(v);
          sh_last[found] = v;
          sh_duty[found] = r.duty;
          sh_slot[found] = 8'd0;
        end
      end else begin
        for (int c = 0; c < NCH; c++)
          if (found < 0 && !sh_used[c]) found = c;
        if (found < 0) r.status = ST_FULL;
        else begin
          r.status = ST_ALLOCATED;
          r.chan = found[3:0];
          r.duty = calibrate(v);
          sh_used[found] = 1'b1;
          sh_pin[found] = it.pin;
          sh_last[found] = v;
          sh_duty[found] = r.duty;
          sh_slot[found] = 8'd0;
        end
      end
    end
    for (int c = 0; c < NCH; c++) r.levels[c] = sh_level[c];
    return r;
  endfunction

  // Driver: presents queued items; holds tvalid across back-to-back beats
  always @(posedge clk) begin
    pwm_item_t it;
    if (rst) s_tvalid <= 1'b0;
    else begin
      if (s_tvalid && s_tready) begin
        it = {s_tuser, s_tdata[7:0], s_tdata[23:8]};
        expected_results.push_back(advance_pwm(it));
        if (it.op == OP_TICK) n_ticks++;
        else n_sets++;
      end
      if ((!s_tvalid || s_tready) && pending_items.size() > 0 &&
          (quiet || $urandom_range(99) >= 8)) begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {it.req, it.pin};
      end else if (s_tvalid && s_tready) s_tvalid <= 1'b0;
    end
  end

  // Monitor: checks each result beat against the oldest prediction
  always @(posedge clk) begin
    pwm_result_t got, want;
    if (!rst) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[30:0];
        n_results++;
        if (got.status == ST_FULL) n_full++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: levels %h/%h chan %0d/%0d status %0d/%0d duty %0d/%0d",
                       want.levels, got.levels, want.chan, got.chan,
                       want.status, got.status, want.duty, got.duty);
          end
        end
      end
      m_tready <= !hold_rx && (quiet || $urandom_range(99) >= 8);
    end
  end

  task automatic push_item(logic op, logic [7:0] pin, logic [15:0] req);
    pending_items.push_back('{op: op, pin: pin, req: req});
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    pwm_item_t it;
    int roll;
    for (int c = 0; c < NCH; c++) begin
      sh_used[c] = 0; sh_pin[c] = 0; sh_duty[c] = 0;
      sh_last[c] = 0; sh_slot[c] = 0; sh_level[c] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, pin zero, unchanged, clamp, beyond table, full table
    push_item(OP_TICK, 8'hFF, 16'hFFFF);
    push_item(OP_SET, 8'd0, 16'd100);       // pin zero: never driven
    push_item(OP_SET, 8'd255, 16'hFFFF);    // clamped to 255
    push_item(OP_SET, 8'd255, 16'd255);     // unchanged after clamp
    push_item(OP_SET, 8'd1, 16'd0);         // duty zero
    push_item(OP_SET, 8'd2, 16'd1);
    push_item(OP_SET, 8'd3, 16'd254);       // beyond the last knot
    push_item(OP_SET, 8'd4, 16'd128);
    push_item(OP_TICK, 8'd0, 16'd0);
    push_item(OP_SET, 8'd4, 16'd128);       // unchanged
    push_item(OP_SET, 8'd4, 16'd3);         // update existing
    for (int p = 5; p < 16; p++) push_item(OP_SET, p[7:0], 16'(p * 17));
    push_item(OP_SET, 8'd200, 16'd50);      // table full
    push_item(OP_TICK, 8'd0, 16'd0);
    drain();

    // Sweep every clamped level on the existing channel of pin 4, ticking in between
    for (int v = 0; v < 256; v++) begin
      push_item(OP_SET, 8'd4, v[15:0]);
      push_item(OP_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)));
    end

    // Long stretch without idling
    drain();
    quiet = 1'b1;
    repeat (300) push_item(OP_TICK, 8'd0, 16'd0);
    drain();
    quiet = 1'b0;

    // Receiver holds off while the sender keeps offering
    hold_rx = 1'b1;
    repeat (40) push_item(1'($urandom_range(1)), 8'($urandom_range(15)),
                          16'($urandom_range(65535)));
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
    drain();   // sender pauses until all results are in

    // Random: mostly ticks and sets on the mapped pins
    for (int n = 0; n < 275; n++) begin
      roll = $urandom_range(99);
      it.op = (roll < 55) ? OP_TICK : OP_SET;
      it.pin = (roll < 95) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      it.req = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                        : 16'($urandom_range(255));
      pending_items.push_back(it);
    end
    drain();
    repeat (60) @(posedge clk);

    $display("Ran %0d ticks and %0d set items, %0d results, %0d table-full.",
             n_ticks, n_sets, n_results, n_full);
    if (errors == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mspc_pkg.sv
rtl/mspc_cell.sv
rtl/mspc_map.sv
rtl/multichannel_soft_pwm_calibrated.sv
rtl/mspc_checker.sv
bench/testbench.sv
